// ----- rtl/comparison_system_euler_integrator_core_defines.svh -----
// assertion macros for the euler integrator core checker
// needs a clock i_clk and an active-low reset i_rst_n in the using scope
`ifndef COMPARISON_SYSTEM_EULER_INTEGRATOR_CORE_DEFINES_SVH
`define COMPARISON_SYSTEM_EULER_INTEGRATOR_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define CEULER_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define CEULER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ceuler_pkg.sv -----
// shared types and constants of the euler integrator core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ceuler_pkg;

    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int SIZE_W   = 4;
    localparam int DT_W     = 17;
    localparam int STEPS_W  = 20;

    localparam logic [ACTION_W-1:0] ACT_MATRIX = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INIT   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd2;

    localparam logic [SIZE_W-1:0]  RST_SIZE  = 4'd8;
    localparam logic [DT_W-1:0]    RST_DT    = 17'd655;
    localparam logic [STEPS_W-1:0] RST_STEPS = 20'd100;

    // vector store banks
    localparam logic [1:0] BANK_INIT = 2'd0;
    localparam logic [1:0] BANK_A    = 2'd1;
    localparam logic [1:0] BANK_B    = 2'd2;

    localparam logic [VALUE_W-1:0] Q_MAX = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_RD,
        ST_T_MUL,
        ST_T_ABS,
        ST_T_LO,
        ST_T_HI,
        ST_T_Q,
        ST_T_ACC,
        ST_T_SAT,
        ST_E_RD,
        ST_E_LD
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/ceuler_if.sv -----
// channel interfaces of the euler integrator core: item in, result out, config writes
// depends on ceuler_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ceuler_item_if import ceuler_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [ADDR_W-1:0]          row;
    logic [ADDR_W-1:0]          column;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, action, row, column, value, input ready);
    modport sink   (input valid, action, row, column, value, output ready);
endinterface

interface ceuler_result_if import ceuler_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ADDR_W-1:0]          index;
    logic signed [VALUE_W-1:0]  final_value;
    logic                       last;

    modport source (output valid, index, final_value, last, input ready);
    modport sink   (input valid, index, final_value, last, output ready);
endinterface

interface ceuler_cfg_if import ceuler_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/comparison_system_euler_integrator_core.sv -----
// Forward-Euler integrator for a linear comparison system, signed Q16.16.
// Channels: i_item (valid/ready) carries matrix writes, initial value writes and
// run commands; o_result (valid/ready) returns one item per vector element after
// a run, index ascending, last set on element n-1; i_cfg (valid/ready, always
// ready) writes size_in_use, time_step and step_count; the user must write them
// only while idle; the block does not enforce it. A matrix or initial value
// write is taken while idle and the block stays ready. A run steps step_count
// times, then emits each element. One shared 33x33 multiplier serves m*v, lo*dt
// and hi*dt of each term in turn, with one matrix and one vector read per term.
// i_item.ready is low from the run command until the last result is loaded.
// A stalled receiver holds the result register and the emit sequence waits;
// a new item may be taken while the final result still waits to be taken.
// Reset (synchronous, active low) returns to idle, drops o_result.valid and
// restores 8, 655 and 100 in the config registers; stores need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module comparison_system_euler_integrator_core import ceuler_pkg::*; #(
    parameter int MAX_SUBSYSTEMS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ceuler_item_if.sink     i_item,
    ceuler_result_if.source o_result,
    ceuler_cfg_if.sink      i_cfg
);

    localparam int IDX_W     = (MAX_SUBSYSTEMS > 1) ? $clog2(MAX_SUBSYSTEMS) : 1;
    localparam int MAT_DEPTH = 1 << (2 * IDX_W);
    localparam int VEC_DEPTH = 4 << IDX_W;
    localparam logic [5:0] MAX_CMP = 6'(MAX_SUBSYSTEMS);

    t_state r_state, n_state;

    logic [SIZE_W-1:0]  r_size;
    logic [DT_W-1:0]    r_dt;
    logic [STEPS_W-1:0] r_count;

    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_out_index, n_out_index;
    logic [VALUE_W-1:0] r_out_value, n_out_value;
    logic               r_out_last, n_out_last;

    logic [IDX_W-1:0]   r_last_idx, n_last_idx;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic [1:0]         r_src, n_src;
    logic [1:0]         r_dst, n_dst;
    logic [63:0]        r_acc, n_acc;
    logic [63:0]        r_prod, n_prod;
    logic [63:0]        r_abs, n_abs;
    logic               r_neg, n_neg;
    logic [48:0]        r_lo, n_lo;
    logic [48:0]        r_q, n_q;
    logic               r_frac, n_frac;

    logic                   mat_we, vec_we, rd_en;
    logic [2*IDX_W-1:0]     mat_waddr, mat_raddr;
    logic [IDX_W+1:0]       vec_waddr, vec_raddr;
    logic [VALUE_W-1:0]     mat_wdata, vec_wdata, mat_rd, vec_rd;

    logic signed [32:0]     mul_a, mul_b;
    logic signed [65:0]     mul_p;
    logic [63:0]            add_b, acc_sum;
    logic                   add_cin;

    logic [5:0]             size_ext;
    logic [IDX_W-1:0]       last_idx_c;
    logic                   row_ok, col_ok, out_free;
    logic [VALUE_W-1:0]     sat_value;

    ceuler_ram #(.WIDTH(VALUE_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mat_we),
        .i_wr_addr (mat_waddr),
        .i_wr_data (mat_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (mat_raddr),
        .o_rd_data (mat_rd)
    );

    ceuler_ram #(.WIDTH(VALUE_W), .DEPTH(VEC_DEPTH)) u_vec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (vec_we),
        .i_wr_addr (vec_waddr),
        .i_wr_data (vec_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (vec_raddr),
        .o_rd_data (vec_rd)
    );

    // shared multiplier and accumulator adder
    assign mul_p   = mul_a * mul_b;
    assign acc_sum = r_acc + add_b + 64'(add_cin);

    assign size_ext   = {2'b00, r_size};
    assign last_idx_c = (r_size == '0) ? '0 :
                        (size_ext > MAX_CMP) ? IDX_W'(MAX_SUBSYSTEMS - 1) :
                        IDX_W'(size_ext - 6'd1);
    assign row_ok     = (6'(i_item.row) < MAX_CMP);
    assign col_ok     = (6'(i_item.column) < MAX_CMP);
    assign out_free   = !r_out_valid || o_result.ready;
    assign sat_value  = r_acc[63] ? '0 : ((|r_acc[62:31]) ? Q_MAX : r_acc[31:0]);

    assign i_item.ready         = (r_state == ST_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_result.valid       = r_out_valid;
    assign o_result.index       = r_out_index;
    assign o_result.final_value = r_out_value;
    assign o_result.last        = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_last_idx  = r_last_idx;
        n_i         = r_i;
        n_j         = r_j;
        n_steps     = r_steps;
        n_src       = r_src;
        n_dst       = r_dst;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_abs       = r_abs;
        n_neg       = r_neg;
        n_lo        = r_lo;
        n_q         = r_q;
        n_frac      = r_frac;

        mat_we    = 1'b0;
        mat_waddr = {IDX_W'(i_item.row), IDX_W'(i_item.column)};
        mat_wdata = i_item.value;
        vec_we    = 1'b0;
        vec_waddr = {BANK_INIT, IDX_W'(i_item.row)};
        vec_wdata = i_item.value;
        rd_en     = 1'b0;
        mat_raddr = {r_i, r_j};
        vec_raddr = {r_src, r_j};
        mul_a     = '0;
        mul_b     = '0;
        add_b     = '0;
        add_cin   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    case (i_item.action)
                        ACT_MATRIX: mat_we = row_ok && col_ok;
                        ACT_INIT:   vec_we = row_ok;
                        ACT_RUN: begin
                            n_last_idx = last_idx_c;
                            n_steps    = r_count;
                            n_src      = BANK_INIT;
                            n_dst      = BANK_A;
                            n_i        = '0;
                            n_j        = '0;
                            n_acc      = '0;
                            n_state    = (r_count == '0) ? ST_E_RD : ST_T_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_T_RD: begin
                rd_en   = 1'b1;
                n_state = ST_T_MUL;
            end
            ST_T_MUL: begin
                mul_a  = {mat_rd[31], mat_rd};
                mul_b  = {vec_rd[31], vec_rd};
                n_prod = mul_p[63:0];
                // own element enters the sum on the diagonal term
                if (r_j == r_i) begin
                    add_b = {{32{vec_rd[31]}}, vec_rd};
                    n_acc = acc_sum;
                end
                n_state = ST_T_ABS;
            end
            ST_T_ABS: begin
                n_neg   = r_prod[63];
                n_abs   = r_prod[63] ? (~r_prod + 64'd1) : r_prod;
                n_state = ST_T_LO;
            end
            ST_T_LO: begin
                mul_a   = {1'b0, r_abs[31:0]};
                mul_b   = {16'b0, r_dt};
                n_lo    = mul_p[48:0];
                n_state = ST_T_HI;
            end
            ST_T_HI: begin
                mul_a   = {1'b0, r_abs[63:32]};
                mul_b   = {16'b0, r_dt};
                n_prod  = mul_p[63:0];
                n_state = ST_T_Q;
            end
            ST_T_Q: begin
                n_q     = {1'b0, r_prod[47:0]} + {32'b0, r_lo[48:32]};
                n_frac  = |r_lo[31:0];
                n_state = ST_T_ACC;
            end
            ST_T_ACC: begin
                // floor of a negative term: -q - frac = ~q + !frac
                add_b   = r_neg ? ~{15'b0, r_q} : {15'b0, r_q};
                add_cin = r_neg && !r_frac;
                n_acc   = acc_sum;
                if (r_j == r_last_idx) begin
                    n_state = ST_T_SAT;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_T_RD;
                end
            end
            ST_T_SAT: begin
                vec_we    = 1'b1;
                vec_waddr = {r_dst, r_i};
                vec_wdata = sat_value;
                n_acc     = '0;
                n_j       = '0;
                if (r_i == r_last_idx) begin
                    n_i     = '0;
                    n_steps = r_steps - 1'b1;
                    n_src   = r_dst;
                    n_dst   = (r_dst == BANK_A) ? BANK_B : BANK_A;
                    n_state = (r_steps == STEPS_W'(1)) ? ST_E_RD : ST_T_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_T_RD;
                end
            end
            ST_E_RD: begin
                rd_en     = 1'b1;
                vec_raddr = {r_src, r_i};
                n_state   = ST_E_LD;
            end
            ST_E_LD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = ADDR_W'(r_i);
                    n_out_value = vec_rd;
                    n_out_last  = (r_i == r_last_idx);
                    if (r_i == r_last_idx) begin
                        n_i     = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_E_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_size      <= RST_SIZE;
            r_dt        <= RST_DT;
            r_count     <= RST_STEPS;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_SIZE:  r_size  <= i_cfg.data[SIZE_W-1:0];
                    CFG_DT:    r_dt    <= i_cfg.data[DT_W-1:0];
                    CFG_STEPS: r_count <= i_cfg.data[STEPS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_last_idx  <= n_last_idx;
        r_i         <= n_i;
        r_j         <= n_j;
        r_steps     <= n_steps;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_acc       <= n_acc;
        r_prod      <= n_prod;
        r_abs       <= n_abs;
        r_neg       <= n_neg;
        r_lo        <= n_lo;
        r_q         <= n_q;
        r_frac      <= n_frac;
    end

endmodule

`default_nettype wire

// ----- rtl/ceuler_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ceuler_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ceuler_checker.sv -----
// port-level checks of the euler integrator core, bound to the top level
// depends on ceuler_pkg and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "comparison_system_euler_integrator_core_defines.svh"

module ceuler_checker import ceuler_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_item_valid,
    input wire logic                i_item_ready,
    input wire logic [ACTION_W-1:0] i_item_action,
    input wire logic                i_res_valid,
    input wire logic                i_res_ready,
    input wire logic [ADDR_W-1:0]   i_res_index,
    input wire logic [VALUE_W-1:0]  i_res_value,
    input wire logic                i_res_last
);

    `CEULER_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_index) && $stable(i_res_value) && $stable(i_res_last), "stalled result item changed")

    `CEULER_ASSERT_SAME(a_busy_mid_run, i_res_valid && !i_res_last, !i_item_ready, "item taken while a run still emits")

    `CEULER_ASSERT_NEXT(a_run_busy, i_item_valid && i_item_ready && (i_item_action == ACT_RUN), !i_item_ready, "run item did not start a run")

    `CEULER_ASSERT_NEXT(a_load_ready, i_item_valid && i_item_ready && (i_item_action != ACT_RUN), i_item_ready, "load item left the block busy")

endmodule

bind comparison_system_euler_integrator_core ceuler_checker u_ceuler_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_item_valid  (i_item.valid),
    .i_item_ready  (i_item.ready),
    .i_item_action (i_item.action),
    .i_res_valid   (o_result.valid),
    .i_res_ready   (o_result.ready),
    .i_res_index   (o_result.index),
    .i_res_value   (o_result.final_value),
    .i_res_last    (o_result.last)
);

`default_nettype wire

// ----- bench/comparison_system_euler_integrator_core_tb.sv -----
`timescale 1ns / 1ps

// self-checking bench for the euler integrator core: matrix and start value loads,
// runs and register writes under random gaps and stalls, checked by an in-bench step model
// depends on ceuler_pkg, the ceuler channel interfaces and comparison_system_euler_integrator_core

module comparison_system_euler_integrator_core_tb;
    import ceuler_pkg::*;

    localparam int N_MAX          = 8;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TAIL_CYCLES    = 20;
    localparam int ITEM_BUDGET    = 370;
    localparam int RUN_COST_CAP   = 20000;
    localparam int HOLD_CYCLES    = 2500;

    localparam logic [ACTION_W-1:0]  ACT_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0]       action;
        logic [ADDR_W-1:0]         row;
        logic [ADDR_W-1:0]         column;
        logic signed [VALUE_W-1:0] value;
    } t_load_item;

    typedef struct {
        logic [ADDR_W-1:0]         index;
        logic signed [VALUE_W-1:0] final_value;
        logic                      last;
    } t_final_value;

    class euler_run_tracker;
        logic [SIZE_W-1:0]         size_reg;
        logic [DT_W-1:0]           dt_reg;
        logic [STEPS_W-1:0]        steps_reg;
        logic signed [VALUE_W-1:0] coeff [N_MAX][N_MAX];
        logic signed [VALUE_W-1:0] start_vec [N_MAX];
        t_final_value              final_values_due [$];
        int                        errors;

        function new();
            size_reg  = RST_SIZE;
            dt_reg    = RST_DT;
            steps_reg = RST_STEPS;
            errors    = 0;
            foreach (coeff[i, j]) coeff[i][j] = '0;
            foreach (start_vec[i]) start_vec[i] = '0;
        endfunction

        function int active_n();
            if (size_reg == 0) return 1;
            if (size_reg > N_MAX) return N_MAX;
            return int'(size_reg);
        endfunction

        function int pending();
            return final_values_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SIZE:  size_reg  = data[SIZE_W-1:0];
                CFG_DT:    dt_reg    = data[DT_W-1:0];
                CFG_STEPS: steps_reg = data[STEPS_W-1:0];
                default: ;
            endcase
        endfunction

        // forward euler over the stored start vector, clamped at zero and saturated
        function void integrate_run();
            logic signed [VALUE_W-1:0] work [N_MAX];
            logic signed [VALUE_W-1:0] nxt [N_MAX];
            logic signed [95:0]        acc;
            logic signed [95:0]        m_w;
            logic signed [95:0]        v_w;
            logic signed [95:0]        dt_w;
            t_final_value              fv;
            int                        n;
            n    = active_n();
            work = start_vec;
            nxt  = start_vec;
            dt_w = dt_reg;
            for (int s = 0; s < steps_reg; s++) begin
                for (int i = 0; i < n; i++) begin
                    acc = work[i];
                    for (int j = 0; j < n; j++) begin
                        m_w = coeff[i][j];
                        v_w = work[j];
                        acc = acc + ((m_w * v_w * dt_w) >>> 32);
                    end
                    if (acc < 0) begin
                        acc = '0;
                    end else if (acc > Q_MAX) begin
                        acc = Q_MAX;
                    end
                    nxt[i] = acc[VALUE_W-1:0];
                end
                work = nxt;
            end
            for (int i = 0; i < n; i++) begin
                fv.index       = ADDR_W'(i);
                fv.final_value = work[i];
                fv.last        = (i == n - 1);
                final_values_due.push_back(fv);
            end
        endfunction

        function void take_item(t_load_item it);
            case (it.action)
                ACT_MATRIX: coeff[it.row][it.column] = it.value;
                ACT_INIT:   start_vec[it.row] = it.value;
                ACT_RUN:    integrate_run();
                default: ;
            endcase
        endfunction

        function void check_result(t_final_value got);
            t_final_value want;
            if (final_values_due.size() == 0) begin
                errors++;
                $error("result with nothing due: index %0d final_value %h last %0d",
                       got.index, got.final_value, got.last);
                return;
            end
            want = final_values_due.pop_front();
            if (got.index !== want.index) begin
                errors++;
                $error("index: expected %0d, got %0d", want.index, got.index);
            end
            if (got.final_value !== want.final_value) begin
                errors++;
                $error("final_value: expected %h, got %h", want.final_value, got.final_value);
            end
            if (got.last !== want.last) begin
                errors++;
                $error("last: expected %0d, got %0d", want.last, got.last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ceuler_item_if   item_ch ();
    ceuler_result_if result_ch ();
    ceuler_cfg_if    cfg_ch ();

    euler_run_tracker tracker;
    bit mat_set [N_MAX][N_MAX];
    bit vec_set [N_MAX];
    int loads_done   = 0;
    int rx_hold_req  = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    comparison_system_euler_integrator_core #(
        .MAX_SUBSYSTEMS(N_MAX)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_final_value got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.index       = result_ch.index;
            got.final_value = result_ch.final_value;
            got.last        = result_ch.last;
            tracker.check_result(got);
        end
        if (i_rst_n && ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                        || (cfg_ch.valid && cfg_ch.ready))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("comparison_system_euler_integrator_core_tb: done, errors");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int stall_left;
        int r;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left > 0) begin
                result_ch.ready = 1'b0;
                stall_left--;
            end else if (calm) begin
                result_ch.ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    result_ch.ready = 1'b1;
                end else begin
                    result_ch.ready = 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
                end
            end
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_coeff();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return int'($urandom_range(0, 262144)) - 131072;
        if (r < 65) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 32'h00A0_0000);
        if (r < 65) return -int'($urandom_range(1, 32'h0010_0000));
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'h0001_0000;
            endcase
        end
        return $urandom;
    endfunction

    task automatic pause_sender();
        int r;
        if (calm) return;
        r = $urandom_range(0, 99);
        if (r < 55) return;
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        repeat (((r < 92) ? $urandom_range(1, 3) : $urandom_range(12, 40)) - 1) @(negedge i_clk);
    endtask

    task automatic send_item(t_load_item it);
        @(negedge i_clk);
        item_ch.valid  = 1'b1;
        item_ch.action = it.action;
        item_ch.row    = it.row;
        item_ch.column = it.column;
        item_ch.value  = it.value;
        do @(posedge i_clk); while (!item_ch.ready);
        tracker.take_item(it);
        if (it.action == ACT_MATRIX) mat_set[it.row][it.column] = 1'b1;
        if (it.action == ACT_INIT) vec_set[it.row] = 1'b1;
        if (it.action != ACT_NONE) loads_done++;
    endtask

    task automatic load(logic [ACTION_W-1:0] act, int row, int col,
                        logic signed [VALUE_W-1:0] val);
        t_load_item it;
        it.action = act;
        it.row    = ADDR_W'(row);
        it.column = ADDR_W'(col);
        it.value  = val;
        pause_sender();
        send_item(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // every entry a run reads gets written first
    task automatic fill_and_run();
        int n;
        n = tracker.active_n();
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (!mat_set[i][j]) load(ACT_MATRIX, i, j, pick_coeff());
            end
        end
        for (int i = 0; i < n; i++) begin
            if (!vec_set[i]) load(ACT_INIT, i, $urandom_range(0, 7), pick_start());
        end
        load(ACT_RUN, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
    endtask

    task automatic noise_items();
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 2))
                0: load(ACT_NONE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
                1: load(ACT_MATRIX, $urandom_range(0, 7), $urandom_range(0, 7), pick_coeff());
                default: load(ACT_INIT, $urandom_range(0, 7), $urandom_range(0, 7), pick_start());
            endcase
        end
    endtask

    task automatic random_sequence();
        int n;
        int r;
        n = tracker.active_n();
        r = $urandom_range(0, 99);
        if (r < 75) begin
            if (r < 15) begin
                for (int i = 0; i < n; i++) begin
                    vec_set[i] = 1'b0;
                    for (int j = 0; j < n; j++) mat_set[i][j] = 1'b0;
                end
            end
            repeat ($urandom_range(0, 2 * n)) begin
                if ($urandom_range(0, 2) == 0) begin
                    load(ACT_INIT, $urandom_range(0, n - 1), $urandom_range(0, 7), pick_start());
                end else begin
                    load(ACT_MATRIX, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                         pick_coeff());
                end
                if ($urandom_range(0, 9) == 0) load(ACT_NONE, 0, 0, $urandom);
            end
            fill_and_run();
        end else begin
            noise_items();
        end
    endtask

    // run cost bounds the step count so large sizes stay short
    task automatic pick_settings();
        int n;
        int r;
        int dt;
        int steps;
        int steps_cap;
        logic [CFG_DATA_W-1:0] d;
        r = $urandom_range(0, 99);
        if (r < 80) n = $urandom_range(1, N_MAX);
        else if (r < 88) n = 0;
        else n = $urandom_range(N_MAX + 1, 15);
        d = $urandom;
        d[SIZE_W-1:0] = SIZE_W'(n);
        if ($urandom_range(0, 3) != 0) d[CFG_DATA_W-1:SIZE_W] = '0;
        write_reg(CFG_SIZE, d);
        r = $urandom_range(0, 99);
        if (r < 60) dt = $urandom_range(1, 4000);
        else if (r < 70) dt = 0;
        else if (r < 80) dt = 65536;
        else if (r < 85) dt = 131071;
        else dt = $urandom_range(0, 131071);
        d = $urandom;
        d[DT_W-1:0] = DT_W'(dt);
        if ($urandom_range(0, 3) != 0) d[CFG_DATA_W-1:DT_W] = '0;
        if ($urandom_range(0, 4) != 0) write_reg(CFG_DT, d);
        n = tracker.active_n();
        steps_cap = RUN_COST_CAP / (n * (7 * n + 1));
        r = $urandom_range(0, 99);
        if (r < 15) steps = 0;
        else if (r < 85) steps = $urandom_range(1, 8);
        else steps = $urandom_range(9, steps_cap);
        write_reg(CFG_STEPS, STEPS_W'(steps));
        calm = ($urandom_range(0, 4) == 0);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        item_ch.valid  = 1'b0;
        item_ch.action = ACT_MATRIX;
        item_ch.row    = '0;
        item_ch.column = '0;
        item_ch.value  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_SIZE;
        cfg_ch.data    = '0;
        tracker        = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // two subsystems at the value extremes, zero steps passes start values through
        calm = 1'b1;
        write_reg(CFG_SIZE, 20'd2);
        write_reg(CFG_DT, 20'd65536);
        write_reg(CFG_STEPS, 20'd0);
        load(ACT_MATRIX, 0, 0, 32'h7FFF_FFFF);
        load(ACT_MATRIX, 0, 1, 32'h8000_0000);
        load(ACT_MATRIX, 1, 0, 32'hFFFF_FFFF);
        load(ACT_MATRIX, 1, 1, 32'h0001_0000);
        load(ACT_MATRIX, 7, 7, 32'h5555_AAAA);
        load(ACT_INIT, 0, 7, 32'h8000_0000);
        load(ACT_INIT, 1, 0, 32'h7FFF_FFFF);
        load(ACT_INIT, 7, 3, 32'h0000_0000);
        load(ACT_NONE, 7, 7, 32'hFFFF_FFFF);
        load(ACT_RUN, 0, 0, 32'h0000_0000);

        // one step: clamp at zero and saturation
        drain_and_settle();
        write_reg(CFG_STEPS, 20'd1);
        load(ACT_RUN, 7, 7, 32'hFFFF_FFFF);

        // size zero acts as one, step above range
        drain_and_settle();
        write_reg(CFG_SIZE, 20'd0);
        write_reg(CFG_DT, 20'd131071);
        write_reg(CFG_STEPS, 20'd3);
        load(ACT_RUN, 3, 4, 32'h0F0F_F0F0);
        load(ACT_NONE, 0, 0, 32'h0000_0000);

        // long result hold while loads and a second run queue up
        drain_and_settle();
        write_reg(CFG_SIZE, 20'd3);
        write_reg(CFG_DT, 20'd655);
        write_reg(CFG_STEPS, 20'd2);
        rx_hold_req = HOLD_CYCLES;
        fill_and_run();
        load(ACT_INIT, 0, 0, pick_start());
        load(ACT_MATRIX, 2, 1, pick_coeff());
        load(ACT_RUN, 0, 0, $urandom);

        // step count at its top and the unused register index, loads only
        drain_and_settle();
        write_reg(CFG_STEPS, 20'hF_FFFF);
        write_reg(CFG_NONE, $urandom);
        calm = 1'b0;
        noise_items();

        while (loads_done < ITEM_BUDGET) begin
            drain_and_settle();
            pick_settings();
            repeat ($urandom_range(1, 4)) random_sequence();
        end

        drain_and_settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("comparison_system_euler_integrator_core_tb: done, clean");
        end else begin
            $display("comparison_system_euler_integrator_core_tb: done, errors");
        end
        $finish;
    end

endmodule
